>>> design/hcbp_pkg.sv
// Package for the Huffman code bit packer.
// Holds the mode codes, field widths and the job record passed from front to back.
// No dependencies.
package hcbp_pkg;

  localparam int CODE_W  = 32;  // width of the code_word field
  localparam int LEN_W   = 6;   // width of the code_length field
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 3;   // pending-bit count in the packing buffer
  localparam int WIN_W   = CODE_W + BYTE_W;  // pending byte plus one code word
  localparam int NB_W    = 3;   // bytes produced by one item, 0..4
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [IN_USER_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [IN_USER_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [IN_USER_W-1:0] MODE_FLUSH  = 2'd2;

  // One unit of work for the packing side: a left-justified code or a flush.
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;   // first code bit in bit CODE_W-1, zeros below
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

>>> design/hcbp_front.sv
// Front of the Huffman code bit packer: accepts beats, keeps the code table,
// turns encode and flush requests into jobs. Depends on hcbp_pkg.
module hcbp_front #(
  parameter int SYMBOLS      = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [hcbp_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                           q_full,
  output logic                           push,
  output hcbp_pkg::job_t                 push_job
);

  localparam int SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ENT_W = MAX_CODE_LEN + hcbp_pkg::LEN_W;

  logic [ENT_W-1:0] mem [SYMBOLS];
  logic [ENT_W-1:0] rd_r;
  logic             s1_v_r, s1_v_nxt;
  logic             s1_flush_r;

  logic [hcbp_pkg::IN_USER_W-1:0] mode;
  logic [7:0]                     sym;
  logic [hcbp_pkg::CODE_W-1:0]    word;
  logic [hcbp_pkg::LEN_W-1:0]     len;
  logic [hcbp_pkg::LEN_W-1:0]     len_sat;
  logic [SYM_W-1:0]               idx;
  logic                           in_range;
  logic                           accept;
  logic                           advance;
  logic                           wr_en;
  logic                           rd_en;
  logic [MAX_CODE_LEN-1:0]        rd_code;
  logic [hcbp_pkg::LEN_W-1:0]     rd_len;

  assign mode     = in_tuser;
  assign sym      = in_tdata[7:0];
  assign word     = in_tdata[39:8];
  assign len      = in_tdata[45:40];
  assign idx      = sym[SYM_W-1:0];
  assign in_range = {1'b0, sym} < 9'(SYMBOLS);
  assign len_sat  = (len > hcbp_pkg::LEN_W'(MAX_CODE_LEN)) ?
                    hcbp_pkg::LEN_W'(MAX_CODE_LEN) : len;

  assign advance   = s1_v_r && !q_full;
  assign in_tready = !s1_v_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign wr_en     = accept && (mode == hcbp_pkg::MODE_LOAD) && in_range;
  assign rd_en     = accept && (mode == hcbp_pkg::MODE_ENCODE) && in_range;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = rd_en || (mode == hcbp_pkg::MODE_FLUSH);
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= {len_sat, word[MAX_CODE_LEN-1:0]};
    end
    if (rd_en) begin
      rd_r <= mem[idx];
    end
    if (accept) begin
      s1_flush_r <= (mode == hcbp_pkg::MODE_FLUSH);
    end
  end

  assign rd_code = rd_r[MAX_CODE_LEN-1:0];
  assign rd_len  = rd_r[ENT_W-1 -: hcbp_pkg::LEN_W];

  // Left-justify the code; bits above the length fall off the top.
  assign push           = advance;
  assign push_job.flush = s1_flush_r;
  assign push_job.len   = rd_len;
  assign push_job.code  = hcbp_pkg::CODE_W'(rd_code) <<
                          (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_len);

endmodule

>>> design/hcbp_queue.sv
// Short job queue between front and back of the Huffman code bit packer.
// Depends on hcbp_pkg.
module hcbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hcbp_pkg::job_t push_job,
  input  logic           pop,
  output hcbp_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  hcbp_pkg::job_t                 slot_r [hcbp_pkg::Q_DEPTH];
  logic [hcbp_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [hcbp_pkg::Q_CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == hcbp_pkg::Q_CNT_W'(hcbp_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/hcbp_back.sv
// Back of the Huffman code bit packer: merges codes into the byte buffer and
// streams out the finished bytes. Depends on hcbp_pkg.
module hcbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  hcbp_pkg::job_t q_head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  logic [hcbp_pkg::BYTE_W-1:0] buf_r, buf_nxt;
  logic [hcbp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [hcbp_pkg::WIN_W-1:0]  win_r, win_nxt;
  logic [hcbp_pkg::NB_W-1:0]   left_r;
  logic [hcbp_pkg::NB_W-1:0]   nb;
  logic [hcbp_pkg::LEN_W-1:0]  total;
  logic                        out_fire;

  assign out_tvalid = (left_r != '0);
  assign out_tlast  = (left_r == hcbp_pkg::NB_W'(1));
  assign out_tdata  = win_r[hcbp_pkg::WIN_W-1 -: hcbp_pkg::BYTE_W];
  assign out_fire   = out_tvalid && out_tready;
  assign pop        = !q_empty && (!out_tvalid || (out_tlast && out_tready));

  always_comb begin
    win_nxt = {buf_r, hcbp_pkg::CODE_W'(0)};
    total   = hcbp_pkg::LEN_W'(cnt_r) + q_head.len;
    nb      = '0;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (q_head.flush) begin
      nb      = (cnt_r != '0) ? hcbp_pkg::NB_W'(1) : '0;
      buf_nxt = '0;
      cnt_nxt = '0;
    end else begin
      win_nxt = win_nxt | ({q_head.code, hcbp_pkg::BYTE_W'(0)} >> cnt_r);
      nb      = total[5:3];
      cnt_nxt = total[2:0];
      case (nb)
        3'd0:    buf_nxt = win_nxt[39:32];
        3'd1:    buf_nxt = win_nxt[31:24];
        3'd2:    buf_nxt = win_nxt[23:16];
        3'd3:    buf_nxt = win_nxt[15:8];
        3'd4:    buf_nxt = win_nxt[7:0];
        default: buf_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      cnt_r  <= '0;
      left_r <= '0;
    end else if (pop) begin
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      left_r <= nb;
    end else if (out_fire) begin
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      win_r <= win_nxt;
    end else if (out_fire) begin
      win_r <= win_r << hcbp_pkg::BYTE_W;
    end
  end

endmodule

>>> design/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: front, job queue and byte packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// Table-driven Huffman encoder with MSB-first byte output. Each input beat
// carries a mode in in_tuser: load writes one code table entry (code and
// length, length saturated to MAX_CODE_LEN), encode appends the stored code
// of a symbol to the bit buffer, flush emits a partly filled byte padded
// with zeros in its low bits. Loads and out-of-range items produce no
// output. The front accepts one beat per cycle unless its lookup stage holds
// a job and the four-entry job queue is full, so loads run at one per cycle
// and wait for output only when that backlog has built up.
// Each encode or flush job produces 0 to 4 bytes. The back takes the next
// job from the queue when the output is idle or as the last byte of the
// current job is taken; a symbol that finishes no byte produces no beat.
// The first output byte of a beat passes the table read register, the
// queue and the output register. Sustained rate is set by the output port:
// one byte per cycle while out_tready is high. The last byte that a beat
// causes carries out_tlast. The code table powers up undefined; encoding
// a symbol never loaded gives unspecified bytes.
module huffman_code_bit_packer #(
  parameter int SYMBOLS      = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
  input  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] mode
  input  logic [hcbp_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_byte
  output logic [7:0]                     out_tdata,
  // last_of_run
  output logic                           out_tlast
);

  logic           q_full, q_empty, push, pop;
  hcbp_pkg::job_t push_job, q_head;

  // Accept beats, hold the code table, produce jobs.
  hcbp_front #(
    .SYMBOLS      (SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouple table lookup from output stalls.
  hcbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Pack code bits into bytes and drive the output beat.
  hcbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Never push into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("job pushed into full queue");

  // Never pop an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty))
    else $error("job popped from empty queue");

  // A load beat leaves no job behind it.
  a_load_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == hcbp_pkg::MODE_LOAD)) |=> !push)
    else $error("load beat produced a job");

endmodule

>>> tb/sv/tb_huffman_code_bit_packer.sv
// Self-checking testbench for huffman_code_bit_packer: directed and random
// load/encode/flush beats against an in-bench bit-packing predictor.
// Depends on hcbp_pkg and the huffman_code_bit_packer design.
module tb_huffman_code_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SYMBOLS = 256;
  localparam int MAX_LEN     = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [hcbp_pkg::IN_USER_W-1:0] MODE_RESERVED = 2'd3;

  // One input beat as the sender queues it; drain_first holds it back until
  // every byte already owed by the block has come out.
  typedef struct {
    logic [hcbp_pkg::IN_USER_W-1:0] mode;
    logic [7:0]                     symbol;
    logic [hcbp_pkg::CODE_W-1:0]    word;
    logic [hcbp_pkg::LEN_W-1:0]     len;
    bit                             drain_first;
  } code_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // [7:0] symbol, [39:8] code_word, [45:40] code_length
  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata;
  logic [hcbp_pkg::IN_USER_W-1:0] in_tuser;   // [1:0] mode
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // [7:0] out_byte
  logic                           out_tlast;  // last_of_run

  huffman_code_bit_packer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of the code table and the packing buffer.
  // ---------------------------------------------------------------------
  logic [hcbp_pkg::CODE_W-1:0] tbl_code [NUM_SYMBOLS];
  logic [hcbp_pkg::LEN_W-1:0]  tbl_len  [NUM_SYMBOLS];
  logic [7:0]                  acc_byte;
  int                          acc_bits;

  packed_byte_t pending_bytes[$];   // bytes the block still owes, oldest first
  code_beat_t   beat_q[$];          // beats not yet put on the bus

  int beats_in;     // beats accepted by the block
  int beats_sent;   // beats put on the bus by the driver
  int n_beats;
  int errors;
  int cycles;

  // Apply one accepted beat to the predictor and queue the bytes it causes.
  task automatic predict_packed_bytes(input logic [hcbp_pkg::IN_USER_W-1:0] mode,
                                      input logic [hcbp_pkg::IN_DATA_W-1:0] data);
    logic [7:0]                  sym;
    logic [hcbp_pkg::CODE_W-1:0] word;
    logic [hcbp_pkg::LEN_W-1:0]  len;
    logic [7:0]                  made [4];
    int                          n;
    int                          i;
    sym  = data[7:0];
    word = data[39:8];
    len  = data[45:40];
    n    = 0;
    case (mode)
      hcbp_pkg::MODE_LOAD: begin
        if (sym < NUM_SYMBOLS) begin
          tbl_code[sym] = word;
          // overlong lengths are stored saturated
          tbl_len[sym]  = (len > MAX_LEN) ? hcbp_pkg::LEN_W'(MAX_LEN) : len;
        end
      end
      hcbp_pkg::MODE_ENCODE: begin
        if (sym < NUM_SYMBOLS) begin
          // walk the code MSB first; bits above the length never enter
          for (i = tbl_len[sym]; i > 0; i--) begin
            if (tbl_code[sym][i-1]) acc_byte[7-acc_bits] = 1'b1;
            acc_bits++;
            if (acc_bits == 8) begin
              if (n < 4) begin
                made[n] = acc_byte;
                n++;
              end
              acc_byte = '0;
              acc_bits = 0;
            end
          end
        end
      end
      hcbp_pkg::MODE_FLUSH: begin
        // an empty buffer flushes to nothing
        if (acc_bits != 0) begin
          made[0]  = acc_byte;
          n        = 1;
          acc_byte = '0;
          acc_bits = 0;
        end
      end
      default: ;  // reserved mode: no output, no state change
    endcase
    for (i = 0; i < n; i++)
      pending_bytes.push_back('{data: made[i], last: (i == n - 1)});
  endtask

  // ---------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n) begin
      // check output first; a beat accepted now cannot produce a byte this edge
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected output beat data=%h last=%b", $time,
                   out_tdata, out_tlast);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $display("%0t: out_byte mismatch expected %h actual %h", $time,
                     want.data, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_of_run mismatch expected %b actual %b", $time,
                     want.last, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_packed_bytes(in_tuser, in_tdata);
        beats_in++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of beats with random gaps, updated at the falling edge.
  // ---------------------------------------------------------------------
  int         burst_left;
  int         gap_left;
  int         settle_left;
  bit         send_now;
  code_beat_t next_beat;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && beats_in != beats_sent) begin
      // hold the current beat until the block takes it
    end else begin
      send_now = 1'b0;
      if (beat_q.size() != 0) begin
        if (beat_q[0].drain_first && pending_bytes.size() != 0) begin
          // wait for every owed byte, then let in-flight zero-byte jobs settle
          settle_left = 10;
        end else if (settle_left > 0) begin
          settle_left--;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          send_now = 1'b1;
        end
      end
      if (send_now) begin
        next_beat  = beat_q.pop_front();
        in_tdata  <= {2'b00, next_beat.len, next_beat.word, next_beat.symbol};
        in_tuser  <= next_beat.mode;
        in_tvalid <= 1'b1;
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // a quarter of the bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: out_tready follows a 16-bit pattern that changes now and then.
  // ---------------------------------------------------------------------
  logic [15:0] rdy_pattern;
  int          rdy_pos;
  int          rdy_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rdy_left <= 0) begin
        case ($urandom_range(0, 3))
          0:       rdy_pattern = 16'hFFFF;                         // no stalls
          1:       rdy_pattern = 16'h0001 << $urandom_range(0, 15); // heavy stalls
          default: rdy_pattern = 16'($urandom) | 16'h0001;
        endcase
        rdy_left = $urandom_range(32, 128);
      end
      rdy_left--;
      out_tready <= rdy_pattern[rdy_pos];
      rdy_pos = (rdy_pos + 1) % 16;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("huffman_code_bit_packer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation. Only symbols already loaded are ever encoded.
  // ---------------------------------------------------------------------
  bit         loaded [NUM_SYMBOLS];
  logic [7:0] loaded_syms[$];

  task automatic add_beat(input logic [hcbp_pkg::IN_USER_W-1:0] mode,
                          input logic [7:0] sym,
                          input logic [hcbp_pkg::CODE_W-1:0] word,
                          input logic [hcbp_pkg::LEN_W-1:0] len,
                          input bit drain);
    beat_q.push_back('{mode: mode, symbol: sym, word: word, len: len,
                       drain_first: drain});
    if (mode == hcbp_pkg::MODE_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Encode beats carry junk in the unused fields; the block must ignore it.
  task automatic add_encode(input logic [7:0] sym, input bit drain);
    add_beat(hcbp_pkg::MODE_ENCODE, sym, $urandom, hcbp_pkg::LEN_W'($urandom), drain);
  endtask

  task automatic add_flush(input bit drain);
    add_beat(hcbp_pkg::MODE_FLUSH, 8'($urandom), $urandom,
             hcbp_pkg::LEN_W'($urandom), drain);
  endtask

  function automatic logic [hcbp_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)       pick_length = hcbp_pkg::LEN_W'($urandom_range(1, 9));   // short codes
    else if (r < 8)  pick_length = hcbp_pkg::LEN_W'($urandom_range(10, 32));
    else if (r == 8) pick_length = '0;                                       // zero length
    else             pick_length = hcbp_pkg::LEN_W'($urandom_range(33, 63)); // overlong
  endfunction

  initial begin
    int r;
    int i;
    rst_n       = 1'b0;
    clk         = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = hcbp_pkg::MODE_LOAD;
    out_tready  = 1'b0;
    acc_byte    = '0;
    acc_bits    = 0;
    beats_in    = 0;
    beats_sent  = 0;
    errors      = 0;
    cycles      = 0;
    burst_left  = 4;
    gap_left    = 0;
    settle_left = 0;
    rdy_pattern = 16'hFFFF;
    rdy_pos     = 0;
    rdy_left    = 0;

    // Directed part: field extremes, every mode and each corner case.
    add_beat(hcbp_pkg::MODE_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd32, 1'b0);  // longest, all ones
    add_beat(hcbp_pkg::MODE_LOAD, 8'd255, 32'h0000_0000, 6'd32, 1'b0);  // longest, all zeros
    add_beat(hcbp_pkg::MODE_LOAD, 8'd1,   32'h0000_0005, 6'd3,  1'b0);  // 101
    add_beat(hcbp_pkg::MODE_LOAD, 8'd2,   32'hFFFF_FFF2, 6'd4,  1'b0);  // junk above length
    add_beat(hcbp_pkg::MODE_LOAD, 8'd3,   32'hABCD_1234, 6'd63, 1'b0);  // overlong, saturates
    add_beat(hcbp_pkg::MODE_LOAD, 8'd4,   32'h1234_5678, 6'd0,  1'b0);  // zero length
    add_beat(hcbp_pkg::MODE_LOAD, 8'd5,   32'h8000_0001, 6'd33, 1'b0);  // just over the limit
    add_flush(1'b0);                                          // empty flush
    add_encode(8'd1, 1'b0);
    add_flush(1'b0);                                          // partial byte, padded
    add_encode(8'd0, 1'b0);                                   // four full bytes
    add_encode(8'd1, 1'b0);
    add_encode(8'd0, 1'b0);                                   // unaligned, four bytes
    add_encode(8'd255, 1'b0);
    add_encode(8'd4, 1'b0);                                   // emits nothing
    add_encode(8'd2, 1'b0);
    add_encode(8'd3, 1'b0);
    add_beat(MODE_RESERVED, 8'd0, $urandom, hcbp_pkg::LEN_W'($urandom), 1'b0);  // ignored
    add_encode(8'd5, 1'b0);
    add_flush(1'b1);                                          // sender drains first
    add_encode(8'd2, 1'b0);
    add_flush(1'b0);

    // Random part: well-formed streams of loads and encodes, some noise.
    for (i = 0; i < RANDOM_BEATS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20)
        add_beat(hcbp_pkg::MODE_LOAD, 8'($urandom), $urandom, pick_length(), 1'b0);
      else if (r < 85)
        add_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   ($urandom_range(0, 49) == 0));
      else if (r < 95)
        add_flush(1'b0);
      else
        add_beat(MODE_RESERVED, 8'($urandom), $urandom,
                 hcbp_pkg::LEN_W'($urandom), 1'b0);
    end
    add_flush(1'b0);
    n_beats = beat_q.size();

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every beat to go in and every owed byte to come out.
    while (beats_in != n_beats) @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    // Give the block time to show any stray output.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
      errors++;
    end

    if (errors == 0) begin
      $display("huffman_code_bit_packer verification clean");
    end else begin
      $display("huffman_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule
